### hdl/svga_bank_register_unit_defines.svh
// Assertion macros used by the checker of the bank register unit.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef SVGA_BANK_REGISTER_UNIT_DEFINES_SVH
`define SVGA_BANK_REGISTER_UNIT_DEFINES_SVH

// Check a property outside of reset.
`define SBRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SBRU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/sbru_pkg.sv
// Package of the bank register unit: transfer types, command and port codes.
// No dependencies; used by the top level and its checker.
package sbru_pkg;

    localparam int CRTC_ENTRIES_DEF = 64;
    localparam int SGA_DEPTH        = 48;   // 32 sequencer + 16 graphics entries

    localparam logic [1:0] CMD_IO_WR  = 2'd0;
    localparam logic [1:0] CMD_IO_RD  = 2'd1;
    localparam logic [1:0] CMD_MEM_WR = 2'd2;
    localparam logic [1:0] CMD_MEM_RD = 2'd3;

    localparam logic [15:0] PORT_MISC_RD  = 16'h03c2;
    localparam logic [15:0] PORT_SEQ_IDX  = 16'h03c4;
    localparam logic [15:0] PORT_SEQ_DAT  = 16'h03c5;
    localparam logic [15:0] PORT_GDC_IDX  = 16'h03ce;
    localparam logic [15:0] PORT_GDC_DAT  = 16'h03cf;
    localparam logic [15:0] PORT_CRTC_IDX = 16'h03d4;
    localparam logic [15:0] PORT_CRTC_DAT = 16'h03d5;

    localparam logic       CFG_CHIP_TYPE = 1'b0;
    localparam logic       CFG_COLOR_IO  = 1'b1;

    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_SGA   = 2'd1;
    localparam logic [1:0] SRC_CRTC  = 2'd2;

    localparam logic [7:0] SEQ_UNLOCK_KEY = 8'h48;
    localparam logic [2:0] EXT_UNLOCK_KEY = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [16:0] address;
        logic [7:0]  data;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [19:0] vram_address;
        logic        vram_write;
        logic        vram_read;
        logic [7:0]  write_data;
    } t_rsp;

endpackage

### hdl/svga_bank_register_unit.sv
// Top level of the bank register unit: register file, unlock rules, bank translation.
// Depends on sbru_pkg.
//
// Usage: the request channel (i_req_valid / o_req_stall / i_req) carries one bus
// access per transfer: io write, io read, memory write or memory read. Every
// request yields exactly one transfer on the response channel (o_rsp_valid /
// i_rsp_stall / o_rsp): read data for io reads, the translated video memory
// address with its read or write strobe for memory accesses, zeros otherwise.
// A request passes the read stage, where the synchronous register file is read, then
// the output register. Sustained throughput is one request per cycle unless the
// receiver stalls; the register file port is read and written once per request,
// at the edge that accepts it, so no forwarding is needed.
// When the receiver stalls, the output register holds and the pipeline stage
// in front of it still takes one more request; after that o_req_stall rises.
// Reset clears indices, the per-entry valid bits and the bank state at once;
// there is no clearing pass and requests are taken right after reset.
// chip_type (byte 0) and color_io (byte 4) are written on the APB port; the user
// must write them only while idle, and the block itself does not enforce it.
module svga_bank_register_unit
    import sbru_pkg::*;
#(
    parameter int CRTC_ENTRIES = CRTC_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output t_rsp        o_rsp
);

    localparam int CRTC_AW = $clog2(CRTC_ENTRIES);
    localparam int SGA_AW  = $clog2(SGA_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic r_chip_type;
    logic r_color_io;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = {31'd0, (paddr[2] == CFG_COLOR_IO) ? r_color_io : r_chip_type};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_type <= 1'b0;
            r_color_io  <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_CHIP_TYPE) begin
                r_chip_type <= pwdata[0];
            end else begin
                r_color_io <= pwdata[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic        req_acc;
    logic        s1_move;
    logic [15:0] port_raw;
    logic [15:0] port;
    logic        mono_alias;
    logic        io_wr;

    logic        r_s1_valid;
    logic [1:0]  r_s1_src;
    t_rsp        r_s1;
    logic        r_out_valid;
    t_rsp        r_out;

    assign req_acc  = i_req_valid & ~o_req_stall;
    assign port_raw = i_req.address[15:0];
    // Swap the 0x3bx and 0x3dx blocks when the CRTC sits at mono addresses.
    assign mono_alias = ~r_color_io &
                        ((port_raw[15:4] == 12'h03d) | (port_raw[15:4] == 12'h03b));
    assign port  = mono_alias ? (port_raw ^ 16'h0060) : port_raw;
    assign io_wr = req_acc & (i_req.command == CMD_IO_WR);

    // ------------------------------------------------------------------
    // Index registers and control shadows of the register file
    // ------------------------------------------------------------------
    logic [7:0] r_seq_index;
    logic [7:0] r_gdc_index;
    logic [5:0] r_crtc_index;

    // Entries that steer locks or banking, mirrored in flops; the register
    // file keeps the copy that io reads return.
    logic [7:0] r_seq6,  n_seq6;
    logic [7:0] r_seq11, n_seq11;
    logic [7:0] r_gdc6,  n_gdc6;
    logic [7:0] r_gdc9,  n_gdc9;
    logic [7:0] r_gdc10, n_gdc10;
    logic [7:0] r_gdc14, n_gdc14;
    logic [7:0] r_gdc15, n_gdc15;
    logic [7:0] r_crtc7,  n_crtc7;
    logic [7:0] r_crtc11, n_crtc11;
    logic [7:0] r_crtc29, n_crtc29;

    // Bank state: the fields the last remap saw. Banks are rebuilt from these
    // on every memory access by adding the bank base and half offset to the address.
    logic [6:0] r_snap_b9,  n_snap_b9;
    logic [6:0] r_snap_ba,  n_snap_ba;
    logic       r_snap_h,   n_snap_h;
    logic       r_snap_g6c, n_snap_g6c;
    logic       r_snap_g14, n_snap_g14;
    logic       r_snap_seq, n_snap_seq;

    // Sequencer rules
    logic       seq_ext;
    logic       seq_unlocked;
    logic       seq_we;
    logic       seq_rd_ff;
    logic [4:0] seq_slot;

    assign seq_ext      = r_seq_index > 8'h07;
    assign seq_unlocked = r_chip_type & (r_seq6 == SEQ_UNLOCK_KEY);
    assign seq_we       = io_wr & (port == PORT_SEQ_DAT) & (~seq_ext | seq_unlocked);
    assign seq_rd_ff    = seq_ext & (~seq_unlocked | (r_seq_index > 8'h12));
    assign seq_slot     = r_seq_index[4:0];

    // Graphics controller rules
    logic       gdc_prot;
    logic       gdc_we;
    logic       gdc_rd_ff;
    logic       gdc_remap_idx;
    logic [3:0] gdc_slot;

    assign gdc_prot  = (r_gdc_index >= 8'h09) & (r_gdc_index < 8'h0f);
    assign gdc_we    = io_wr & (port == PORT_GDC_DAT) &
                       (~gdc_prot | (r_gdc15[2:0] == EXT_UNLOCK_KEY));
    assign gdc_rd_ff = gdc_prot & r_gdc15[4];
    assign gdc_slot  = r_gdc_index[3:0];
    // Only the exact index remaps; aliased indices above 15 just store.
    assign gdc_remap_idx = (r_gdc_index == 8'h06) | (r_gdc_index == 8'h09) |
                           (r_gdc_index == 8'h0a) | (r_gdc_index == 8'h0e);

    // CRTC rules
    logic       crtc_wp;
    logic       crtc_in_range;
    logic       crtc_is_id;
    logic       crtc_ext_lock;
    logic       crtc_we;
    logic       crtc_rd_ff;
    logic [7:0] crtc_wdata;

    assign crtc_wp       = r_crtc11[7];
    assign crtc_in_range = int'(r_crtc_index) < CRTC_ENTRIES;
    assign crtc_is_id    = (r_crtc_index >= 6'h31) & (r_crtc_index <= 6'h37);
    assign crtc_ext_lock = (r_crtc_index > 6'h29) & (r_crtc29[2:0] != EXT_UNLOCK_KEY);
    // Write protect leaves only the line-compare bit of index 7 open.
    assign crtc_wdata = ((r_crtc_index == 6'h07) & crtc_wp) ?
                        {r_crtc7[7:5], i_req.data[4], r_crtc7[3:0]} : i_req.data;
    assign crtc_we = io_wr & (port == PORT_CRTC_DAT) & crtc_in_range & ~crtc_is_id &
                     ~crtc_ext_lock & ~((r_crtc_index < 6'h07) & crtc_wp);
    assign crtc_rd_ff = (r_crtc_index > 6'h29) & (r_crtc_index < 6'h30) &
                        ((r_crtc29 & 8'h88) != 8'h80);

    logic remap;
    assign remap = (seq_we & (r_seq_index == 8'h11)) | (gdc_we & gdc_remap_idx);

    always_comb begin
        n_seq6   = r_seq6;
        n_seq11  = r_seq11;
        n_gdc6   = r_gdc6;
        n_gdc9   = r_gdc9;
        n_gdc10  = r_gdc10;
        n_gdc14  = r_gdc14;
        n_gdc15  = r_gdc15;
        n_crtc7  = r_crtc7;
        n_crtc11 = r_crtc11;
        n_crtc29 = r_crtc29;
        if (seq_we) begin
            case (seq_slot)
                5'h06:   n_seq6  = i_req.data;
                5'h11:   n_seq11 = i_req.data;
                default: ;
            endcase
        end
        if (gdc_we) begin
            case (gdc_slot)
                4'h6:    n_gdc6  = i_req.data;
                4'h9:    n_gdc9  = i_req.data;
                4'ha:    n_gdc10 = i_req.data;
                4'he:    n_gdc14 = i_req.data;
                4'hf:    n_gdc15 = i_req.data;
                default: ;
            endcase
        end
        if (crtc_we) begin
            case (r_crtc_index)
                6'h07:   n_crtc7  = crtc_wdata;
                6'h11:   n_crtc11 = crtc_wdata;
                6'h29:   n_crtc29 = crtc_wdata;
                default: ;
            endcase
        end
    end

    // Remap works on the values this write leaves behind.
    always_comb begin
        n_snap_b9  = r_snap_b9;
        n_snap_ba  = r_snap_ba;
        n_snap_h   = r_snap_h;
        n_snap_g6c = r_snap_g6c;
        n_snap_g14 = r_snap_g14;
        n_snap_seq = r_snap_seq;
        if (remap) begin
            n_snap_b9  = n_gdc9[6:0];
            n_snap_ba  = n_gdc10[6:0];
            n_snap_h   = ~n_gdc6[3];
            n_snap_g6c = |n_gdc6[3:2];
            n_snap_g14 = n_gdc14[3];
            n_snap_seq = n_seq11[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_index  <= '0;
            r_gdc_index  <= '0;
            r_crtc_index <= '0;
            r_seq6       <= '0;
            r_seq11      <= '0;
            r_gdc6       <= '0;
            r_gdc9       <= '0;
            r_gdc10      <= '0;
            r_gdc14      <= '0;
            r_gdc15      <= '0;
            r_crtc7      <= '0;
            r_crtc11     <= '0;
            r_crtc29     <= '0;
            r_snap_b9    <= '0;
            r_snap_ba    <= '0;
            r_snap_h     <= 1'b0;   // all banks zero out of reset
            r_snap_g6c   <= 1'b0;
            r_snap_g14   <= 1'b0;
            r_snap_seq   <= 1'b0;
        end else begin
            if (io_wr) begin
                case (port)
                    PORT_SEQ_IDX:  r_seq_index <= i_req.data;
                    PORT_GDC_IDX:  r_gdc_index <= i_req.data;
                    PORT_CRTC_IDX: r_crtc_index <= i_req.data[5:0] &
                                                   (r_chip_type ? 6'h3f : 6'h1f);
                    default: ;
                endcase
            end
            r_seq6     <= n_seq6;
            r_seq11    <= n_seq11;
            r_gdc6     <= n_gdc6;
            r_gdc9     <= n_gdc9;
            r_gdc10    <= n_gdc10;
            r_gdc14    <= n_gdc14;
            r_gdc15    <= n_gdc15;
            r_crtc7    <= n_crtc7;
            r_crtc11   <= n_crtc11;
            r_crtc29   <= n_crtc29;
            r_snap_b9  <= n_snap_b9;
            r_snap_ba  <= n_snap_ba;
            r_snap_h   <= n_snap_h;
            r_snap_g6c <= n_snap_g6c;
            r_snap_g14 <= n_snap_g14;
            r_snap_seq <= n_snap_seq;
        end
    end

    // ------------------------------------------------------------------
    // Register file: sequencer + graphics memory, CRTC memory
    // ------------------------------------------------------------------
    logic [SGA_AW-1:0]       sga_addr;
    logic                    sga_we;
    logic [7:0]              r_sga_mem [SGA_DEPTH];
    logic [SGA_DEPTH-1:0]    r_sga_vld;
    logic [7:0]              r_sga_q;
    logic                    r_sga_q_vld;

    logic [CRTC_AW-1:0]      crtc_addr;
    logic [7:0]              r_crtc_mem [CRTC_ENTRIES];
    logic [CRTC_ENTRIES-1:0] r_crtc_vld;
    logic [7:0]              r_crtc_q;
    logic                    r_crtc_q_vld;

    // Sequencer entries fill the lower 32 words, graphics entries the next 16.
    assign sga_addr  = (port == PORT_SEQ_DAT) ? SGA_AW'({1'b0, seq_slot}) :
                                                SGA_AW'({2'b10, gdc_slot});
    assign sga_we    = seq_we | gdc_we;
    assign crtc_addr = r_crtc_index[CRTC_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (sga_we) begin
            r_sga_mem[sga_addr] <= i_req.data;
        end
        if (req_acc) begin
            r_sga_q <= r_sga_mem[sga_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (crtc_we) begin
            r_crtc_mem[crtc_addr] <= crtc_wdata;
        end
        if (req_acc) begin
            r_crtc_q <= r_crtc_mem[crtc_addr];
        end
    end

    // Never-written entries read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sga_vld    <= '0;
            r_crtc_vld   <= '0;
            r_sga_q_vld  <= 1'b0;
            r_crtc_q_vld <= 1'b0;
        end else begin
            if (sga_we) begin
                r_sga_vld[sga_addr] <= 1'b1;
            end
            if (crtc_we) begin
                r_crtc_vld[crtc_addr] <= 1'b1;
            end
            if (req_acc) begin
                r_sga_q_vld  <= r_sga_vld[sga_addr];
                r_crtc_q_vld <= r_crtc_vld[crtc_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Bank translation
    // ------------------------------------------------------------------
    logic [1:0]  bsel;
    logic [6:0]  bank_base;
    logic [19:0] vram_addr;

    assign bsel = i_req.address[16:15];

    always_comb begin
        if (r_snap_seq) begin
            // Separate read and write windows.
            bank_base = (i_req.command == CMD_MEM_WR) ? r_snap_ba : r_snap_b9;
        end else if (r_snap_g14) begin
            // Shared window pair; split by odd/even or by halves.
            bank_base = (r_snap_g6c ? bsel[0] : bsel[1]) ? r_snap_b9 : r_snap_ba;
        end else begin
            bank_base = r_snap_b9;
        end
    end

    assign vram_addr = 20'(i_req.address[14:0]) + {1'b0, bank_base, 12'h000} +
                       ((bsel[0] & r_snap_h) ? 20'h08000 : 20'h00000);

    // ------------------------------------------------------------------
    // Response assembly at the accepting edge
    // ------------------------------------------------------------------
    function automatic logic [7:0] id_byte(input logic [5:0] idx, input logic chip);
        logic [7:0] b;
        case (idx)
            6'h31:   b = 8'h57;
            6'h32:   b = 8'h44;
            6'h33:   b = 8'h39;
            6'h34:   b = 8'h30;
            6'h35:   b = 8'h43;
            6'h36:   b = chip ? 8'h31 : 8'h00;
            6'h37:   b = chip ? 8'h31 : 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    logic [1:0] s1_src;
    t_rsp       s1_rsp;

    always_comb begin
        s1_src = SRC_CONST;
        s1_rsp = '0;
        case (i_req.command)
            CMD_IO_RD: begin
                case (port)
                    PORT_MISC_RD:  s1_rsp.read_data = 8'h10;
                    PORT_SEQ_IDX:  s1_rsp.read_data = r_seq_index;
                    PORT_SEQ_DAT: begin
                        if (seq_rd_ff) begin
                            s1_rsp.read_data = 8'hff;
                        end else begin
                            s1_src = SRC_SGA;
                        end
                    end
                    PORT_GDC_IDX:  s1_rsp.read_data = r_gdc_index;
                    PORT_GDC_DAT: begin
                        if (gdc_rd_ff) begin
                            s1_rsp.read_data = 8'hff;
                        end else begin
                            s1_src = SRC_SGA;
                        end
                    end
                    PORT_CRTC_IDX: s1_rsp.read_data = {2'b00, r_crtc_index};
                    PORT_CRTC_DAT: begin
                        if (crtc_rd_ff) begin
                            s1_rsp.read_data = 8'hff;
                        end else if (crtc_is_id) begin
                            s1_rsp.read_data = id_byte(r_crtc_index, r_chip_type);
                        end else if (crtc_in_range) begin
                            s1_src = SRC_CRTC;
                        end
                    end
                    default:       s1_rsp.read_data = 8'hff;
                endcase
            end
            CMD_MEM_WR: begin
                s1_rsp.vram_address = vram_addr;
                s1_rsp.vram_write   = 1'b1;
                s1_rsp.write_data   = i_req.data;
            end
            CMD_MEM_RD: begin
                s1_rsp.vram_address = vram_addr;
                s1_rsp.vram_read    = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline: read stage, then output register
    // ------------------------------------------------------------------
    t_rsp out_next;

    assign s1_move     = r_s1_valid & (~r_out_valid | ~i_rsp_stall);
    assign o_req_stall = r_s1_valid & ~s1_move;

    always_comb begin
        out_next = r_s1;
        case (r_s1_src)
            SRC_SGA:  out_next.read_data = r_sga_q_vld  ? r_sga_q  : 8'h00;
            SRC_CRTC: out_next.read_data = r_crtc_q_vld ? r_crtc_q : 8'h00;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (~i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1     <= s1_rsp;
            r_s1_src <= s1_src;
        end
        if (s1_move) begin
            r_out <= out_next;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

### hdl/sbru_chk.sv
// Port-level checker of the bank register unit, attached by bind.
// Depends on sbru_pkg and svga_bank_register_unit_defines.svh.
`include "svga_bank_register_unit_defines.svh"

module sbru_chk
    import sbru_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);

    `SBRU_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_rsp_valid, "response valid after reset")

    `SBRU_ASSERT(a_latency, i_req_valid && !o_req_stall |-> ##2 o_rsp_valid, "response late")

    `SBRU_ASSERT(a_stall_cause, o_req_stall |-> o_rsp_valid && i_rsp_stall, "stall without full output")

    `SBRU_ASSERT(a_one_strobe, o_rsp_valid |-> !(o_rsp.vram_write && o_rsp.vram_read), "both strobes set")

    `SBRU_ASSERT(a_rsp_hold, o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp), "response moved under stall")

endmodule

bind svga_bank_register_unit sbru_chk u_sbru_chk (.*);
